/* rtl/core/sbd_pkg.sv */
// ----------------------------------------------------------------------------
// sbd_pkg
// shared types and constants for the distance sorter
// ----------------------------------------------------------------------------
package sbd_pkg;

   localparam int SBD_MAX_NODES = 64;
   localparam int ID_W          = 8;
   localparam int DIST_W        = 8;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic [ID_W-1:0]   id;
   } entry_type;

   typedef struct packed {
      logic [ID_W-1:0] id;
      logic            last;
   } emit_type;

   typedef enum logic [1:0] {
      ST_LOAD,
      ST_SCAN,
      ST_DRAIN,
      ST_EMIT
   } state_type;

endpackage

/* rtl/core/sbd_store.sv */
// ----------------------------------------------------------------------------
// sbd_store
// entry memory, one write and one registered read port
// ----------------------------------------------------------------------------
module sbd_store
   import sbd_pkg::*;
#(
   parameter int DEPTH = SBD_MAX_NODES,
   parameter int AW    = 6
) (
   input  logic            clock,
   input  logic            mem_we,
   input  logic [AW-1:0]   mem_waddr,
   input  entry_type       mem_wdata,
   input  logic            mem_re,
   input  logic [AW-1:0]   mem_raddr,
   output entry_type       mem_rdata
);

   entry_type store_ff [DEPTH];
   entry_type rdata_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_ff[mem_waddr] <= mem_wdata;
      end
      if (mem_re) begin
         rdata_ff <= store_ff[mem_raddr];
      end
   end

   assign mem_rdata = rdata_ff;

endmodule

/* rtl/core/sbd_sort.sv */
// ----------------------------------------------------------------------------
// sbd_sort
// list loading and selection sort sequencer over the entry memory
// ----------------------------------------------------------------------------
module sbd_sort
   import sbd_pkg::*;
#(
   parameter int MAX_NODES = SBD_MAX_NODES,
   parameter int AW        = 6,
   parameter int CW        = 7
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [ID_W-1:0]    req_node_id,
   input  logic [DIST_W-1:0]  req_distance,
   input  logic               req_last_in,
   output logic               mem_we,
   output logic [AW-1:0]      mem_waddr,
   output entry_type          mem_wdata,
   output logic               mem_re,
   output logic [AW-1:0]      mem_raddr,
   input  entry_type          mem_rdata,
   output logic               emit_valid,
   input  logic               emit_ready,
   output emit_type           emit
);

   state_type        state_ff, state_in;
   logic [AW-1:0]    i_ff, i_in;
   logic [AW-1:0]    j_ff, j_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             rd_pend_ff, rd_pend_in;
   logic [AW-1:0]    rd_idx_ff, rd_idx_in;
   entry_type        best_ff, best_in;
   logic [AW-1:0]    best_idx_ff, best_idx_in;
   entry_type        head_ff, head_in;
   logic             pass_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_LOAD;
         count_ff   <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         rd_pend_ff <= rd_pend_in;
      end
      i_ff        <= i_in;
      j_ff        <= j_in;
      rd_idx_ff   <= rd_idx_in;
      best_ff     <= best_in;
      best_idx_ff <= best_idx_in;
      head_ff     <= head_in;
   end

   // running minimum, first strict minimum wins
   always_comb begin
      best_in     = best_ff;
      best_idx_in = best_idx_ff;
      head_in     = head_ff;
      if (rd_pend_ff) begin
         if (rd_idx_ff == i_ff) begin
            best_in     = mem_rdata;
            best_idx_in = i_ff;
            head_in     = mem_rdata;
         end else if (mem_rdata.distance < best_ff.distance) begin
            best_in     = mem_rdata;
            best_idx_in = rd_idx_ff;
         end
      end
   end

   assign pass_last = ((CW'(i_ff) + CW'(1)) == count_ff);

   always_comb begin
      state_in   = state_ff;
      i_in       = i_ff;
      j_in       = j_ff;
      count_in   = count_ff;
      rd_pend_in = 1'b0;
      rd_idx_in  = j_ff;
      mem_we     = 1'b0;
      mem_waddr  = best_idx_ff;
      mem_wdata  = head_ff;
      mem_re     = 1'b0;
      mem_raddr  = j_ff;
      emit_valid = 1'b0;
      emit.id    = best_ff.id;
      emit.last  = pass_last;
      req_stall  = 1'b1;
      case (state_ff)
         ST_LOAD: begin
            req_stall = 1'b0;
            if (req_valid) begin
               if (count_ff < CW'(MAX_NODES)) begin
                  mem_we             = 1'b1;
                  mem_waddr          = count_ff[AW-1:0];
                  mem_wdata.distance = req_distance;
                  mem_wdata.id       = req_node_id;
                  count_in           = count_ff + CW'(1);
               end
               if (req_last_in) begin
                  state_in = ST_SCAN;
                  i_in     = '0;
                  j_in     = '0;
               end
            end
         end
         ST_SCAN: begin
            mem_re     = 1'b1;
            rd_pend_in = 1'b1;
            if ((CW'(j_ff) + CW'(1)) == count_ff) begin
               state_in = ST_DRAIN;
            end else begin
               j_in = j_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            emit_valid = 1'b1;
            if (emit_ready) begin
               // swap: old head moves to where the minimum was
               mem_we = 1'b1;
               if (pass_last) begin
                  state_in = ST_LOAD;
                  count_in = '0;
               end else begin
                  i_in     = i_ff + AW'(1);
                  j_in     = i_ff + AW'(1);
                  state_in = ST_SCAN;
               end
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

endmodule

/* rtl/core/selection_sort_by_distance_top.sv */
// ----------------------------------------------------------------------------
// selection_sort_by_distance_top
// sorts a list of node ids by ascending distance, selection sort in memory
// ----------------------------------------------------------------------------
// usage:
//   req_ transfers load one node (id, distance) per cycle into the entry
//   memory while req_stall is low; nodes beyond MAX_NODES are dropped. the
//   transfer with req_last_in closes the list and starts the sort; req_stall
//   stays high from then until the last sorted id has been handed to the
//   output stage. pass i scans entries i..n-1 through the single read port:
//   it reads each entry in turn, waits out the read latency in a drain
//   state, then writes the swap back and loads the output register with the
//   pass minimum. a list of n entries thus gives its ids one per pass. the
//   write of each swap happens in the emit state before the next pass reads,
//   so reads never meet a pending write.
//   rsp_ holds a registered result; while rsp_stall is high it holds and
//   the sequencer waits at the end of its pass.
//   reset (synchronous) empties the list and the output register; memory
//   contents are not cleared.
// ----------------------------------------------------------------------------
module selection_sort_by_distance_top
   import sbd_pkg::*;
#(
   parameter int MAX_NODES = SBD_MAX_NODES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [ID_W-1:0]    req_node_id,
   input  logic [DIST_W-1:0]  req_distance,
   input  logic               req_last_in,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [ID_W-1:0]    rsp_sorted_id,
   output logic               rsp_last_out
);

   localparam int AW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CW = $clog2(MAX_NODES + 1);

   logic            mem_we;
   logic [AW-1:0]   mem_waddr;
   entry_type       mem_wdata;
   logic            mem_re;
   logic [AW-1:0]   mem_raddr;
   entry_type       mem_rdata;
   logic            emit_valid;
   logic            emit_ready;
   emit_type        emit;

   logic            rsp_valid_ff, rsp_valid_in;
   emit_type        rsp_data_ff, rsp_data_in;

   sbd_store #(
      .DEPTH (MAX_NODES),
      .AW    (AW)
   ) u_store (
      .clock     (clock),
      .mem_we    (mem_we),
      .mem_waddr (mem_waddr),
      .mem_wdata (mem_wdata),
      .mem_re    (mem_re),
      .mem_raddr (mem_raddr),
      .mem_rdata (mem_rdata)
   );

   sbd_sort #(
      .MAX_NODES (MAX_NODES),
      .AW        (AW),
      .CW        (CW)
   ) u_sort (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_node_id  (req_node_id),
      .req_distance (req_distance),
      .req_last_in  (req_last_in),
      .mem_we       (mem_we),
      .mem_waddr    (mem_waddr),
      .mem_wdata    (mem_wdata),
      .mem_re       (mem_re),
      .mem_raddr    (mem_raddr),
      .mem_rdata    (mem_rdata),
      .emit_valid   (emit_valid),
      .emit_ready   (emit_ready),
      .emit         (emit)
   );

   // output register
   assign emit_ready = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (emit_valid && emit_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = emit;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_sorted_id = rsp_data_ff.id;
   assign rsp_last_out  = rsp_data_ff.last;

   // no input transfer while the sorter hands out a result
   a_no_load_while_emit: assert property (@(posedge clock) disable iff (reset)
      emit_valid |-> req_stall)
      else $error("input accepted while sorting");

   // a swap write never lands on the entry being read
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      mem_we && mem_re |-> mem_waddr != mem_raddr)
      else $error("read and write to the same entry");

   // once the final id is handed out the list is reopened
   a_open_after_last: assert property (@(posedge clock) disable iff (reset)
      emit_valid && emit_ready && emit.last |=> !req_stall)
      else $error("list not reopened after final id");

   // results only come out of a pass end with room in the output stage
   a_emit_into_room: assert property (@(posedge clock) disable iff (reset)
      emit_valid && emit_ready |=> rsp_valid && rsp_sorted_id == $past(emit.id))
      else $error("sorted id lost at output stage");

endmodule
